// File: rtl/mcoa_pkg.sv
// Shared types and constants of the multichannel oversample accumulator.
package mcoa_pkg;

    localparam int DEF_CHANNELS       = 16;
    localparam int DEF_MAX_EXTRA_BITS = 4;

    localparam int CH_BITS    = 4;
    localparam int SMP_W      = 12;
    localparam int SUM_W      = 20;
    localparam int RES_W      = 16;
    localparam int SCAN_W     = 8;
    localparam int MASK_W     = 16;
    localparam int XB_W       = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MASK = 1'b0,
        REG_EXTRA_BITS  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               opcode;
        logic [CH_BITS-1:0] channel;
        logic [SMP_W-1:0]   sample;
        logic               end_of_scan;
    } t_in_word;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             not_enabled;
    } t_out_word;

    // write-back request from the update stage to the channel store
    typedef struct packed {
        logic               sum_we;
        logic               res_we;
        logic [CH_BITS-1:0] idx;
        logic [SUM_W-1:0]   sum;
        logic [RES_W-1:0]   res;
    } t_wr_req;

endpackage

// File: rtl/mcoa_store.sv
// Per-channel sum and result memories with entry valid bits and write forwarding.
module mcoa_store #(
    parameter int CHANNELS = mcoa_pkg::DEF_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [mcoa_pkg::CH_BITS-1:0]    i_rd_idx,
    input  mcoa_pkg::t_wr_req               i_wr,
    output logic [mcoa_pkg::SUM_W-1:0]      o_rd_sum,
    output logic [mcoa_pkg::RES_W-1:0]      o_rd_res
);
    import mcoa_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SUM_W-1:0]    mem_sum [CHANNELS];
    logic [RES_W-1:0]    mem_res [CHANNELS];
    logic [CHANNELS-1:0] r_sum_vld;
    logic [CHANNELS-1:0] r_res_vld;

    logic [SUM_W-1:0] r_sum_rd;
    logic [RES_W-1:0] r_res_rd;
    logic             r_sum_rd_vld;
    logic             r_res_rd_vld;
    logic             r_sum_fwd;
    logic             r_res_fwd;
    logic [SUM_W-1:0] r_sum_fwd_data;
    logic [RES_W-1:0] r_res_fwd_data;

    logic [CH_W-1:0] rd_a;
    logic [CH_W-1:0] wr_a;
    logic            same_entry;

    assign rd_a       = i_rd_idx[CH_W-1:0];
    assign wr_a       = i_wr.idx[CH_W-1:0];
    assign same_entry = (i_wr.idx == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr.sum_we) begin
            mem_sum[wr_a] <= i_wr.sum;
        end
        if (i_wr.res_we) begin
            mem_res[wr_a] <= i_wr.res;
        end
    end

    // read port; a write to the same entry at this edge is caught by the bypass
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sum_rd       <= mem_sum[rd_a];
            r_res_rd       <= mem_res[rd_a];
            r_sum_rd_vld   <= r_sum_vld[rd_a];
            r_res_rd_vld   <= r_res_vld[rd_a];
            r_sum_fwd      <= i_wr.sum_we && same_entry;
            r_res_fwd      <= i_wr.res_we && same_entry;
            r_sum_fwd_data <= i_wr.sum;
            r_res_fwd_data <= i_wr.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
            r_res_vld <= '0;
        end else begin
            if (i_wr.sum_we) begin
                r_sum_vld[wr_a] <= 1'b1;
            end
            if (i_wr.res_we) begin
                r_res_vld[wr_a] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_sum_fwd) begin
            o_rd_sum = r_sum_fwd_data;
        end else if (r_sum_rd_vld) begin
            o_rd_sum = r_sum_rd;
        end else begin
            o_rd_sum = '0;
        end
        if (r_res_fwd) begin
            o_rd_res = r_res_fwd_data;
        end else if (r_res_rd_vld) begin
            o_rd_res = r_res_rd;
        end else begin
            o_rd_res = '0;
        end
    end

endmodule

// File: rtl/multichannel_oversample_accumulator.sv
// Top level of the multichannel oversample accumulator.
//
//  port group   dir   handshake                    payload
//  in           in    i_in_valid / o_in_ready      i_in_word  (t_in_word)
//  out          out   o_out_valid / i_out_ready    o_out_word (t_out_word)
//  cfg          in    i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  One word per clock. A word reads its channel's entries at acceptance and
//  updates them in the next cycle; a write to the same entry at acceptance
//  is bypassed. A read word's result goes from the update stage into the
//  output register and waits there until taken. Reset is synchronous and
//  clears the entry valid bits at once, so words are taken in the first
//  cycle after reset. The input stalls only when a read waits in the update
//  stage behind a full output register that is not being taken.
module multichannel_oversample_accumulator #(
    parameter int CHANNELS       = mcoa_pkg::DEF_CHANNELS,
    parameter int MAX_EXTRA_BITS = mcoa_pkg::DEF_MAX_EXTRA_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mcoa_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mcoa_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_we,
    input  logic [mcoa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mcoa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mcoa_pkg::*;

    logic [MASK_W-1:0] r_mask;
    logic [XB_W-1:0]   r_xbits;
    logic [SCAN_W-1:0] r_scan_count;
    logic [SCAN_W-1:0] n_scan_count;

    logic      r_s1_valid;
    t_in_word  r_s1;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;

    logic    in_fire;
    logic    s1_fire;
    logic    s1_is_read;
    logic    s1_enabled;
    t_wr_req wr;

    logic [SUM_W-1:0]   cur_sum;
    logic [RES_W-1:0]   cur_res;
    logic [XB_W-1:0]    k_eff;
    logic [SCAN_W:0]    span;
    logic [SCAN_W-1:0]  last_scan;
    logic               final_scan;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [SUM_W-1:0]   sum_shift;
    logic [RES_W-1:0]   res_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_xbits <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE_MASK: r_mask  <= i_cfg_data[MASK_W-1:0];
                REG_EXTRA_BITS:  r_xbits <= i_cfg_data[XB_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_is_read = (r_s1.opcode == OP_READ);
    assign s1_fire    = r_s1_valid && (!s1_is_read || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    mcoa_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_fire),
        .i_rd_idx (i_in_word.channel),
        .i_wr     (wr),
        .o_rd_sum (cur_sum),
        .o_rd_res (cur_res)
    );

    // update stage
    always_comb begin
        s1_enabled = ({1'b0, r_s1.channel} < (CH_BITS+1)'(CHANNELS))
                     && r_mask[r_s1.channel];
        k_eff = (r_xbits > XB_W'(MAX_EXTRA_BITS)) ? XB_W'(MAX_EXTRA_BITS) : r_xbits;
        span = (SCAN_W+1)'(1) << {k_eff, 1'b0};
        last_scan = SCAN_W'(span - (SCAN_W+1)'(1));
        final_scan = (r_scan_count >= last_scan);

        sum_wide = {1'b0, cur_sum} + (SUM_W+1)'(r_s1.sample);
        sum_sat = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        sum_shift = sum_sat >> k_eff;
        res_sat = (|sum_shift[SUM_W-1:RES_W]) ? '1 : sum_shift[RES_W-1:0];

        wr.sum_we = s1_fire && !s1_is_read && s1_enabled;
        wr.res_we = wr.sum_we && final_scan;
        wr.idx    = r_s1.channel;
        wr.sum    = final_scan ? '0 : sum_sat;
        wr.res    = res_sat;

        n_scan_count = r_scan_count;
        if (s1_fire && !s1_is_read && r_s1.end_of_scan) begin
            n_scan_count = final_scan ? '0 : r_scan_count + SCAN_W'(1);
        end

        n_out.not_enabled = !s1_enabled;
        n_out.value       = s1_enabled ? cur_res : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scan_count <= '0;
        end else begin
            r_scan_count <= n_scan_count;
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && s1_is_read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_word;
        end
        if (s1_fire && s1_is_read) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_s1))
        else $error("update stage lost its word while stalled");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.res_we |-> wr.sum_we && wr.sum == '0)
        else $error("result committed without clearing the sum");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.sum_we |-> !s1_is_read && r_s1_valid)
        else $error("memory written by a read word");

    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && s1_is_read |=> r_out_valid)
        else $error("read result not presented");

    a_scan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !s1_is_read && r_s1.end_of_scan && final_scan |=> r_scan_count == '0)
        else $error("scan count did not wrap after the final scan");
`endif

endmodule

// File: test/multichannel_oversample_accumulator_tb.sv
// Self-checking testbench of the multichannel oversample accumulator.
module multichannel_oversample_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcoa_pkg::*;

    localparam int          CHANNELS      = DEF_CHANNELS;
    localparam int unsigned MAX_XB        = DEF_MAX_EXTRA_BITS;
    localparam int unsigned SUM_MAX       = (1 << SUM_W) - 1;
    localparam int unsigned RES_MAX       = (1 << RES_W) - 1;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_LIMIT   = 10000;
    localparam int          RANDOM_WORDS  = 80;
    localparam int          REPORT_MAX    = 10;
    localparam longint      TIMEOUT_NS    = 20_000_000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_out_word             o_out_word;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [SUM_W-1:0]  acc_sum     [CHANNELS];
    logic [RES_W-1:0]  conv_result [CHANNELS];
    logic [SCAN_W-1:0] scan_idx;
    logic [MASK_W-1:0] en_mask;
    logic [XB_W-1:0]   xtra_bits;

    t_out_word expected_reads[$];

    logic quiet = 1'b0;
    int   stall_left = 0;
    int   mismatches = 0;
    int   n_words = 0;
    int   n_reads = 0;
    int   n_checked = 0;
    int   n_settings = 0;

    multichannel_oversample_accumulator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            acc_sum[c]     = '0;
            conv_result[c] = '0;
        end
        scan_idx  = '0;
        en_mask   = '0;
        xtra_bits = '0;
    end

    function automatic void predict_word(t_in_word w);
        int unsigned k;
        int unsigned last;
        int unsigned s;
        int unsigned r;
        logic        en;
        logic        final_scan;
        t_out_word   rd;
        en = (int'(w.channel) < CHANNELS) && en_mask[w.channel];
        if (w.opcode == OP_READ) begin
            rd.value       = en ? conv_result[w.channel] : '0;
            rd.not_enabled = !en;
            expected_reads.push_back(rd);
            n_reads++;
            return;
        end
        k          = (xtra_bits > MAX_XB) ? MAX_XB : int'(xtra_bits);
        last       = (1 << (2 * k)) - 1;
        final_scan = (int'(scan_idx) >= last);
        if (en) begin
            s = acc_sum[w.channel] + w.sample;
            if (s > SUM_MAX) s = SUM_MAX;
            if (final_scan) begin
                r = s >> k;
                if (r > RES_MAX) r = RES_MAX;
                conv_result[w.channel] = r[RES_W-1:0];
                acc_sum[w.channel]     = '0;
            end else begin
                acc_sum[w.channel] = s[SUM_W-1:0];
            end
        end
        if (w.end_of_scan) begin
            if (final_scan) scan_idx = '0;
            else scan_idx = scan_idx + 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MASK_W-1:0] pick_channels(int nmax);
        logic [MASK_W-1:0] m;
        m = '0;
        repeat ($urandom_range(1, nmax)) m[$urandom_range(0, CHANNELS - 1)] = 1'b1;
        return m;
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    // receiver: random stalls, mostly short, a few long
    always @(posedge i_clk) begin
        int r;
        if (quiet) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (expected_reads.size() == 0) begin
                log_mismatch($sformatf(
                    "result word with nothing expected: value=%0d not_enabled=%0b",
                    o_out_word.value, o_out_word.not_enabled));
            end else begin
                want = expected_reads.pop_front();
                if (o_out_word.value !== want.value ||
                    o_out_word.not_enabled !== want.not_enabled) begin
                    log_mismatch($sformatf(
                        "read mismatch: expected %0d/%0b, got %0d/%0b (value/not_enabled)",
                        want.value, want.not_enabled, o_out_word.value, o_out_word.not_enabled));
                end
            end
        end
    end

    // Leaves valid high on return; the next call drops it only if it idles first.
    task automatic send_word(t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(w);
        n_words++;
    endtask

    task automatic send_sample(logic [CH_BITS-1:0] ch, logic [SMP_W-1:0] smp, logic eos);
        send_word('{opcode: OP_SAMPLE, channel: ch, sample: smp, end_of_scan: eos});
    endtask

    task automatic send_read(logic [CH_BITS-1:0] ch);
        send_word('{opcode: OP_READ, channel: ch, sample: SMP_W'($urandom),
                    end_of_scan: 1'($urandom)});
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_reads.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ENABLE_MASK) en_mask = data[MASK_W-1:0];
        else xtra_bits = data[XB_W-1:0];
    endtask

    // Idle the block, then write both registers; junk in the unused high bits.
    task automatic configure(logic [MASK_W-1:0] mask, logic [XB_W-1:0] xb);
        drain();
        write_reg(REG_ENABLE_MASK, mask);
        write_reg(REG_EXTRA_BITS, {(CFG_DATA_W - XB_W)'($urandom), xb});
        n_settings++;
    endtask

    task automatic test_after_reset();
        send_read(4'd0);
        send_read(4'd15);
    endtask

    task automatic test_single_scan();
        configure(16'hFFFF, 3'd0);
        send_read(4'd0);
        send_sample(4'd0, 12'hFFF, 1'b0);
        send_sample(4'd15, 12'h000, 1'b0);
        send_sample(4'd5, 12'h555, 1'b0);
        send_sample(4'd3, 12'h123, 1'b0);
        send_sample(4'd3, 12'hABC, 1'b0);
        send_sample(4'd10, 12'hAAA, 1'b1);
        send_read(4'd0);
        send_read(4'd15);
        send_read(4'd5);
        send_read(4'd3);
        send_read(4'd10);
    endtask

    // A disabled channel's sample is not summed but still ends the scan.
    task automatic test_disabled_channel();
        configure(16'h0001, 3'd1);
        send_sample(4'd0, 12'd100, 1'b0);
        send_sample(4'd3, 12'd200, 1'b1);
        send_sample(4'd0, 12'hFFF, 1'b1);
        send_sample(4'd0, 12'd7, 1'b1);
        send_sample(4'd0, 12'd1234, 1'b0);
        send_sample(4'd9, 12'd50, 1'b1);
        send_read(4'd0);
        send_read(4'd3);
    endtask

    // extra_bits 7 clamps to the max; lowering it mid-run makes the scan final.
    task automatic test_lowered_resolution();
        configure(16'h8000, 3'd7);
        repeat (10) send_sample(4'd15, SMP_W'($urandom), 1'b1);
        send_read(4'd15);
        configure(16'h8000, 3'd1);
        send_sample(4'd15, 12'hFFF, 1'b0);
        send_read(4'd15);
        send_sample(4'd15, 12'h800, 1'b1);
    endtask

    // Pile many full-scale samples into one scan to saturate sum and result.
    task automatic test_sum_saturation();
        configure(16'h0010, 3'd1);
        repeat (300) send_sample(4'd4, 12'hFFF, 1'b0);
        repeat (3) send_sample(4'd4, 12'hFFF, 1'b1);
        send_sample(4'd4, 12'hFFF, 1'b1);
        send_read(4'd4);
    endtask

    task automatic test_full_resolution();
        logic [CH_BITS-1:0] ch;
        ch = CH_BITS'($urandom);
        configure(MASK_W'(1) << ch, 3'd4);
        for (int s = 0; s < 256; s++) begin
            if (s % 64 == 0) send_read(ch);
            send_sample(ch, SMP_W'($urandom), 1'b1);
        end
        send_read(ch);
    endtask

    task automatic test_random_traffic();
        int                goal;
        int unsigned       xb;
        int unsigned       scans;
        int unsigned       r;
        int                last_ch;
        logic [MASK_W-1:0] mask;
        goal = n_words + RANDOM_WORDS;
        while (n_words < goal) begin
            quiet <= ($urandom_range(0, 4) == 0);
            xb = $urandom_range(0, 3);
            r  = $urandom_range(0, 9);
            if (xb >= 2) mask = pick_channels(xb == 2 ? 6 : 2);
            else if (r == 0) mask = '0;
            else if (r == 1) mask = '1;
            else mask = MASK_W'($urandom);
            configure(mask, XB_W'(xb));
            scans = (1 << (2 * xb)) * $urandom_range(1, 2) + $urandom_range(0, 3);
            last_ch = 0;
            for (int c = 0; c < CHANNELS; c++) if (mask[c]) last_ch = c;
            repeat (scans) begin
                if (mask == '0) send_sample(CH_BITS'($urandom), SMP_W'($urandom), 1'b1);
                for (int c = 0; c < CHANNELS; c++) begin
                    if (!mask[c]) continue;
                    r = $urandom_range(0, 99);
                    if (r < 12) send_read(CH_BITS'($urandom));
                    else if (r < 17)
                        send_sample(CH_BITS'($urandom), SMP_W'($urandom), 1'($urandom));
                    // drop the end-of-scan mark now and then
                    send_sample(CH_BITS'(c), SMP_W'($urandom),
                                (c == last_ch) && ($urandom_range(0, 29) != 0));
                end
            end
            for (int c = 0; c < CHANNELS; c++) send_read(CH_BITS'(c));
        end
        quiet <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_single_scan();
        test_disabled_channel();
        test_lowered_resolution();
        test_sum_saturation();
        test_full_resolution();
        test_random_traffic();
        drain();
        if (expected_reads.size() != 0)
            log_mismatch($sformatf("%0d read results never arrived", expected_reads.size()));
        mismatches += (expected_reads.size() > 1) ? expected_reads.size() - 1 : 0;
        $display("Covered %0d words, %0d reads, %0d results checked, %0d settings.",
                 n_words, n_reads, n_checked, n_settings);
        $display("Masks from empty to full, extra_bits 0 to 7, %0d mismatches.", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
